// File: hw/rtl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Densifier package
// Shared types and constants of the polyline segment densifier.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned MaxSteps = 63;
  localparam int unsigned StepW = $clog2(MaxSteps + 1);
  localparam int unsigned CoordW = 32;
  localparam int unsigned StepLenW = 31;
  localparam logic [StepLenW-1:0] StepLenReset = StepLenW'(6554);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_FIT,
    ST_DIV,
    ST_EMIT
  } psd_state_e;

  typedef struct packed {
    logic load;
    logic sq_step;
    logic fit_step;
    logic div_start;
    logic div_step;
    logic emit_start;
    logic emit_next;
  } psd_cmd_t;

  typedef struct packed {
    logic sq_done;
    logic fit_done;
    logic div_done;
    logic emit_last;
  } psd_sts_t;

endpackage

// File: hw/rtl/psd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Densifier controller
// Sequences squaring, step count search, division and point emission.
// ----------------------------------------------------------------------------
module psd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              start_of_path_i,
  output logic              in_stall_o,
  input  logic              out_valid_o_i,
  input  logic              out_stall_i,
  output psd_pkg::psd_cmd_t cmd_o,
  input  psd_pkg::psd_sts_t sts_i
);
  import psd_pkg::*;

  psd_state_e state_q, state_d;
  logic       have_prev_q, have_prev_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load  = 1'b1;
          have_prev_d = 1'b1;
          if (!start_of_path_i && have_prev_q) begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_done) begin
          state_d = ST_FIT;
        end
      end
      ST_FIT: begin
        cmd_o.fit_step = 1'b1;
        if (sts_i.fit_done) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.emit_start = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_valid_o_i && !out_stall_i) begin
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_o_i && !out_stall_i && sts_i.emit_last)
      |=> (state_q == ST_IDLE))
    else $error("emission did not end after the last word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input open while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !out_valid_o_i)
    else $error("output valid while idle");

endmodule

// File: hw/rtl/psd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Densifier datapath
// Squared length, piece count search, per-axis division and point stepping.
// ----------------------------------------------------------------------------
module psd_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [psd_pkg::StepLenW-1:0]         cfg_wdata_i,
  input  logic signed [psd_pkg::CoordW-1:0]    coord_x_i,
  input  logic signed [psd_pkg::CoordW-1:0]    coord_y_i,
  input  logic signed [psd_pkg::CoordW-1:0]    coord_z_i,
  input  psd_pkg::psd_cmd_t                    cmd_i,
  output psd_pkg::psd_sts_t                    sts_o,
  output logic signed [psd_pkg::CoordW-1:0]    point_x_o,
  output logic signed [psd_pkg::CoordW-1:0]    point_y_o,
  output logic signed [psd_pkg::CoordW-1:0]    point_z_o,
  output logic                                 last_of_segment_o
);
  import psd_pkg::*;

  localparam int unsigned DW = CoordW + 1;
  localparam int unsigned MW = CoordW;
  localparam int unsigned SqW = 2 * MW + 2;
  localparam int unsigned SsW = 2 * StepLenW;
  localparam int unsigned TsqW = SsW + 2 * StepW;
  localparam int unsigned QW = DW;

  logic [StepLenW-1:0]    step_len_q;
  logic signed [CoordW-1:0] prev_q [3];
  logic signed [CoordW-1:0] cur_q [3];
  logic signed [DW-1:0]   delta_q [3];
  logic [1:0]             sq_idx_q;
  logic [SqW-1:0]         sum_q;
  logic [2*MW-1:0]        sq_prod_q;
  logic                   sq_pend_q;
  logic [StepW-1:0]       k_q;
  logic [StepW-1:0]       n_q;
  logic [1:0]             fit_ph_q;
  logic [SsW-1:0]         ss_q;
  logic [TsqW-1:0]        inc_q;
  logic [TsqW-1:0]        tsq_q;
  logic                   fit_done_q;
  logic [QW-1:0]          rem_q [3];
  logic [QW-1:0]          quo_q [3];
  logic [$clog2(QW+1)-1:0] div_cnt_q;
  logic signed [CoordW-1:0] step_q [3];
  logic signed [CoordW-1:0] pt_q [3];
  logic [StepW-1:0]       j_q;

  logic [MW-1:0]          mag_sel;
  logic signed [DW-1:0]   d_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_len_q <= StepLenReset;
      prev_q[0]  <= '0;
      prev_q[1]  <= '0;
      prev_q[2]  <= '0;
    end else begin
      if (cfg_we_i) begin
        step_len_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        prev_q[0] <= coord_x_i;
        prev_q[1] <= coord_y_i;
        prev_q[2] <= coord_z_i;
      end
    end
  end

  always_comb begin
    d_sel = delta_q[0];
    case (sq_idx_q)
      2'd1: d_sel = delta_q[1];
      2'd2: d_sel = delta_q[2];
      default: d_sel = delta_q[0];
    endcase
    mag_sel = d_sel[DW-1] ? MW'(-d_sel) : MW'(d_sel);
  end

  // The squared candidate length (k * step)^2 grows by (2k - 1) * step^2 per
  // candidate, so the search needs only additions after one squaring.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= prev_q[i];
      end
      delta_q[0] <= DW'(coord_x_i) - DW'(prev_q[0]);
      delta_q[1] <= DW'(coord_y_i) - DW'(prev_q[1]);
      delta_q[2] <= DW'(coord_z_i) - DW'(prev_q[2]);
      sq_idx_q   <= '0;
      sum_q      <= '0;
      sq_pend_q  <= 1'b0;
      k_q        <= StepW'(1);
      n_q        <= StepW'(1);
      fit_ph_q   <= '0;
      fit_done_q <= 1'b0;
    end
    if (cmd_i.sq_step) begin
      if (sq_pend_q) begin
        sum_q <= sum_q + SqW'(sq_prod_q);
      end
      if (sq_idx_q != 2'd3) begin
        sq_prod_q <= mag_sel * mag_sel;
        sq_pend_q <= 1'b1;
        sq_idx_q  <= sq_idx_q + 2'd1;
      end else begin
        sq_pend_q <= 1'b0;
      end
    end
    if (cmd_i.fit_step && !fit_done_q) begin
      unique case (fit_ph_q)
        2'd0: begin
          ss_q     <= step_len_q * step_len_q;
          inc_q    <= '0;
          tsq_q    <= '0;
          fit_ph_q <= 2'd1;
        end
        2'd1: begin
          tsq_q    <= tsq_q + inc_q + TsqW'(ss_q);
          inc_q    <= inc_q + TsqW'({ss_q, 1'b0});
          fit_ph_q <= 2'd2;
        end
        default: begin
          fit_ph_q <= 2'd1;
          if (tsq_q <= TsqW'(sum_q)) begin
            n_q <= k_q;
            if (k_q == StepW'(MaxSteps)) begin
              fit_done_q <= 1'b1;
            end else begin
              k_q <= k_q + StepW'(1);
            end
          end else begin
            fit_done_q <= 1'b1;
          end
        end
      endcase
    end
    if (cmd_i.div_start) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= '0;
        quo_q[i] <= delta_q[i][DW-1] ? QW'(-delta_q[i]) : QW'(delta_q[i]);
      end
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step && div_cnt_q != ($clog2(QW+1))'(QW)) begin
      for (int i = 0; i < 3; i++) begin
        logic [QW:0] r;
        r = {rem_q[i], quo_q[i][QW-1]};
        if (r >= (QW+1)'(n_q)) begin
          rem_q[i] <= QW'(r - (QW+1)'(n_q));
          quo_q[i] <= {quo_q[i][QW-2:0], 1'b1};
        end else begin
          rem_q[i] <= QW'(r);
          quo_q[i] <= {quo_q[i][QW-2:0], 1'b0};
        end
      end
      div_cnt_q <= div_cnt_q + ($clog2(QW+1))'(1);
    end
    if (cmd_i.emit_start) begin
      for (int i = 0; i < 3; i++) begin
        step_q[i] <= delta_q[i][DW-1] ? CoordW'(-quo_q[i]) : CoordW'(quo_q[i]);
        pt_q[i]   <= cur_q[i];
      end
      j_q <= '0;
    end
    if (cmd_i.emit_next) begin
      for (int i = 0; i < 3; i++) begin
        pt_q[i] <= pt_q[i] + step_q[i];
      end
      j_q <= j_q + StepW'(1);
    end
  end

  assign sts_o.sq_done   = (sq_idx_q == 2'd3) && !sq_pend_q;
  assign sts_o.fit_done  = fit_done_q;
  assign sts_o.div_done  = (div_cnt_q == ($clog2(QW+1))'(QW));
  assign sts_o.emit_last = (j_q == n_q);

  assign point_x_o = pt_q[0];
  assign point_y_o = pt_q[1];
  assign point_z_o = pt_q[2];
  assign last_of_segment_o = (j_q == n_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.fit_done |-> (n_q != '0) && (n_q <= StepW'(MaxSteps)))
    else $error("piece count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_next |-> (j_q < n_q))
    else $error("point index past piece count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> sts_o.fit_done)
    else $error("division started before count search");

endmodule

// File: hw/rtl/polyline_segment_densifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline segment densifier
// Emits evenly spaced 3D points along each segment of a waypoint path.
// ----------------------------------------------------------------------------
// A waypoint word is taken on in_valid_i with in_stall_o low. The first
// waypoint of a path (start_of_path_i, or none stored yet) is stored and
// emits nothing; the block is ready again on the next cycle.
// Any later waypoint emits n+1 point words, n being the segment length over
// step_length, limited to 1..63. Work before the first point: squaring and
// summing of the three axis deltas, the piece count search (a setup step,
// then an update and a compare per candidate) and bit-serial division,
// all three axes in parallel. Then one point word per cycle while
// out_stall_i is low; a stall holds the word.
// The search loop dominates the worst-case work per waypoint.
// The input is stalled for the whole of this, up to the last point word.
// step_length is written via cfg_we_i and cfg_wdata_i, by the user only while
// idle; the block does not enforce this. Reset clears the stored waypoint to
// zero, marks no waypoint stored and sets step_length to 6554.
// ----------------------------------------------------------------------------
module polyline_segment_densifier_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psd_pkg::StepLenW-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              start_of_path_i,
  input  logic signed [psd_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [psd_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [psd_pkg::CoordW-1:0] coord_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [psd_pkg::CoordW-1:0] point_x_o,
  output logic signed [psd_pkg::CoordW-1:0] point_y_o,
  output logic signed [psd_pkg::CoordW-1:0] point_z_o,
  output logic                              last_of_segment_o
);
  import psd_pkg::*;

  psd_cmd_t   cmd;
  psd_sts_t   sts;
  logic       emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else if (cmd.emit_start) begin
      emit_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i && last_of_segment_o) begin
      emit_q <= 1'b0;
    end
  end

  assign out_valid_o = emit_q;

  psd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .start_of_path_i(start_of_path_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o_i  (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  psd_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .coord_z_i        (coord_z_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .point_x_o        (point_x_o),
    .point_y_o        (point_y_o),
    .point_z_o        (point_z_o),
    .last_of_segment_o(last_of_segment_o)
  );

endmodule
